### rtl/core/ppd_pkg.sv
// ppd_pkg: shared constants and types for the periodic pair distance block
// no dependencies; imported by every rtl module, both checkers and the testbench

package ppd_pkg;

	localparam int COORD_WIDTH_DEF = 24;
	localparam int CFG_INDEX_WIDTH = 2;

	// configuration register indexes
	typedef enum logic [CFG_INDEX_WIDTH-1:0] {
		REG_PERIODIC_ENABLE = 2'd0,
		REG_BOX_SIZE_X      = 2'd1,
		REG_BOX_SIZE_Y      = 2'd2,
		REG_BOX_SIZE_Z      = 2'd3
	} cfg_reg_t;

endpackage

### rtl/core/periodic_pair_distance_top.sv
// periodic_pair_distance_top: minimum-image euclidean distance of two points
// uses ppd_pkg, ppd_axis, ppd_square and ppd_sqrt_cell
//
//  channel | handshake             | beat contents
//  --------+-----------------------+--------------------------------------------
//  pair    | pair_valid/pair_stall | point_a_x/y/z, point_b_x/y/z (unsigned)
//  dist    | dist_valid/dist_stall | distance, COORD_WIDTH+1 bits
//  cfg     | cfg_valid/cfg_ready   | cfg_index, cfg_data (write only)
//
// one pair beat per cycle while the output is not stalled; the pipe is the axis,
// square and sum stages and a chain of square root cells, one cell per root bit
// every stage moves on one enable, low only while a finished beat sits stalled
// in the output register; pair_stall follows dist_stall in the same cycle
// reset clears the stage valid bits and loads the register reset values;
// cfg_ready is always high

module periodic_pair_distance_top
	import ppd_pkg::*;
#(
	parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	// pair channel
	input  logic                       pair_valid,
	output logic                       pair_stall,
	input  logic [COORD_WIDTH-1:0]     point_a_x,
	input  logic [COORD_WIDTH-1:0]     point_a_y,
	input  logic [COORD_WIDTH-1:0]     point_a_z,
	input  logic [COORD_WIDTH-1:0]     point_b_x,
	input  logic [COORD_WIDTH-1:0]     point_b_y,
	input  logic [COORD_WIDTH-1:0]     point_b_z,
	// distance channel
	output logic                       dist_valid,
	input  logic                       dist_stall,
	output logic [COORD_WIDTH:0]       distance,
	// configuration writes
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
	input  logic [COORD_WIDTH-1:0]     cfg_data
);

	localparam int ROOT_WIDTH = COORD_WIDTH + 1;   // distance bits, one cell each
	localparam int SUM_WIDTH  = 2 * ROOT_WIDTH;    // three squares, exact
	localparam int SQ_WIDTH   = 2 * COORD_WIDTH;
	localparam int FRONT      = 6;                 // axis 3, square 2, sum 1
	localparam int DEPTH      = FRONT + ROOT_WIDTH;

	// configuration registers
	logic                   periodic_enable_q;
	logic [COORD_WIDTH-1:0] box_size_x_q;
	logic [COORD_WIDTH-1:0] box_size_y_q;
	logic [COORD_WIDTH-1:0] box_size_z_q;

	// pipeline control
	logic             en;
	logic [DEPTH-1:0] vld_q;

	// datapath
	logic [COORD_WIDTH-1:0] mag_x, mag_y, mag_z;
	logic [SQ_WIDTH-1:0]    sq_x, sq_y, sq_z;
	logic [SUM_WIDTH-1:0]   sum_s6;

	logic [SUM_WIDTH-1:0]    rad_c  [ROOT_WIDTH+1];
	logic [ROOT_WIDTH+2:0]   rem_c  [ROOT_WIDTH+1];
	logic [ROOT_WIDTH-1:0]   root_c [ROOT_WIDTH+1];

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			periodic_enable_q <= 1'b1;
			box_size_x_q      <= '1;
			box_size_y_q      <= '1;
			box_size_z_q      <= '1;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_reg_t'(cfg_index))
				REG_PERIODIC_ENABLE: periodic_enable_q <= cfg_data[0];
				REG_BOX_SIZE_X:      box_size_x_q      <= cfg_data;
				REG_BOX_SIZE_Y:      box_size_y_q      <= cfg_data;
				REG_BOX_SIZE_Z:      box_size_z_q      <= cfg_data;
				default: ;
			endcase
		end
	end

	// the whole pipe holds only when the output beat is waiting
	assign en         = !vld_q[DEPTH-1] || !dist_stall;
	assign pair_stall = !en;
	assign dist_valid = vld_q[DEPTH-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[DEPTH-2:0], pair_valid};
		end
	end

	// per-axis wrap and magnitude
	ppd_axis #(.COORD_WIDTH(COORD_WIDTH)) u_axis_x (
		.clk(clk), .en(en), .wrap(periodic_enable_q),
		.a(point_a_x), .b(point_b_x), .box(box_size_x_q), .mag(mag_x)
	);
	ppd_axis #(.COORD_WIDTH(COORD_WIDTH)) u_axis_y (
		.clk(clk), .en(en), .wrap(periodic_enable_q),
		.a(point_a_y), .b(point_b_y), .box(box_size_y_q), .mag(mag_y)
	);
	// z axis uses its own difference
	ppd_axis #(.COORD_WIDTH(COORD_WIDTH)) u_axis_z (
		.clk(clk), .en(en), .wrap(periodic_enable_q),
		.a(point_a_z), .b(point_b_z), .box(box_size_z_q), .mag(mag_z)
	);

	// squares
	ppd_square #(.COORD_WIDTH(COORD_WIDTH)) u_sq_x (
		.clk(clk), .en(en), .mag(mag_x), .sq(sq_x)
	);
	ppd_square #(.COORD_WIDTH(COORD_WIDTH)) u_sq_y (
		.clk(clk), .en(en), .mag(mag_y), .sq(sq_y)
	);
	ppd_square #(.COORD_WIDTH(COORD_WIDTH)) u_sq_z (
		.clk(clk), .en(en), .mag(mag_z), .sq(sq_z)
	);

	// sum of squares, two spare bits keep it exact
	always_ff @(posedge clk) begin
		if (en) begin
			sum_s6 <= SUM_WIDTH'(sq_x) + SUM_WIDTH'(sq_y) + SUM_WIDTH'(sq_z);
		end
	end

	// square root chain: the top root bit first, two radicand bits per cell
	assign rad_c[0]  = sum_s6;
	assign rem_c[0]  = '0;
	assign root_c[0] = '0;

	for (genvar i = 0; i < ROOT_WIDTH; i++) begin : g_cell
		ppd_sqrt_cell #(.ROOT_WIDTH(ROOT_WIDTH)) u_cell (
			.clk   (clk),
			.en    (en),
			.rad_i (rad_c[i]),
			.rem_i (rem_c[i]),
			.root_i(root_c[i]),
			.rad_o (rad_c[i+1]),
			.rem_o (rem_c[i+1]),
			.root_o(root_c[i+1])
		);
	end

	// the last cell's register is the output register
	assign distance = root_c[ROOT_WIDTH];

endmodule

### rtl/core/ppd_axis.sv
// ppd_axis: one axis difference, minimum-image wrap and magnitude, three stages
// uses ppd_pkg; stages advance together on en

module ppd_axis
	import ppd_pkg::*;
#(
	parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
	input  logic                   clk,
	input  logic                   en,
	input  logic                   wrap,
	input  logic [COORD_WIDTH-1:0] a,
	input  logic [COORD_WIDTH-1:0] b,
	input  logic [COORD_WIDTH-1:0] box,
	output logic [COORD_WIDTH-1:0] mag
);

	localparam int DW = COORD_WIDTH + 1;   // signed difference
	localparam int TW = COORD_WIDTH + 3;   // twice the difference against the box
	localparam int WW = COORD_WIDTH + 2;   // wrapped difference

	logic signed [DW-1:0]          d;
	logic signed [TW-1:0]          d2;
	logic signed [TW-1:0]          box_t;
	logic signed [TW-1:0]          t_sub;
	logic signed [TW-1:0]          t_add;
	logic                          sub_c;
	logic                          add_c;
	logic signed [DW-1:0]          d_s1;
	logic [COORD_WIDTH-1:0]        box_s1;
	logic                          sub_s1;
	logic                          add_s1;
	logic signed [WW-1:0]          w_c;
	logic signed [WW-1:0]          w_s2;
	logic [WW-1:0]                 m_c;

	// stage 1: difference and wrap decision
	always_comb begin
		d     = $signed({1'b0, a}) - $signed({1'b0, b});
		d2    = $signed({d[DW-1], d, 1'b0});
		box_t = $signed({3'b000, box});
		t_sub = d2 - box_t;
		t_add = d2 + box_t;
		sub_c = wrap && !t_sub[TW-1] && (t_sub != '0);
		add_c = wrap && !sub_c && (t_add[TW-1] || (t_add == '0));
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d_s1   <= d;
			box_s1 <= box;
			sub_s1 <= sub_c;
			add_s1 <= add_c;
		end
	end

	// stage 2: apply the wrap
	always_comb begin
		if (sub_s1) begin
			w_c = $signed({d_s1[DW-1], d_s1}) - $signed({2'b00, box_s1});
		end else if (add_s1) begin
			w_c = $signed({d_s1[DW-1], d_s1}) + $signed({2'b00, box_s1});
		end else begin
			w_c = $signed({d_s1[DW-1], d_s1});
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			w_s2 <= w_c;
		end
	end

	// stage 3: magnitude, always below 2^COORD_WIDTH
	assign m_c = w_s2[WW-1] ? (~w_s2 + 1'b1) : w_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			mag <= m_c[COORD_WIDTH-1:0];
		end
	end

endmodule

### rtl/core/ppd_square.sv
// ppd_square: square of an axis magnitude from half-width partial products
// uses ppd_pkg; two stages, advance on en

module ppd_square
	import ppd_pkg::*;
#(
	parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
	input  logic                     clk,
	input  logic                     en,
	input  logic [COORD_WIDTH-1:0]   mag,
	output logic [2*COORD_WIDTH-1:0] sq
);

	localparam int LO = COORD_WIDTH / 2;
	localparam int HI = COORD_WIDTH - LO;
	localparam int SW = 2 * COORD_WIDTH;

	logic [HI-1:0]    hi;
	logic [LO-1:0]    lo;
	logic [2*HI-1:0]  hh_s1;
	logic [HI+LO-1:0] hl_s1;
	logic [2*LO-1:0]  ll_s1;

	assign hi = mag[COORD_WIDTH-1:LO];
	assign lo = mag[LO-1:0];

	// stage 1: partial products
	always_ff @(posedge clk) begin
		if (en) begin
			hh_s1 <= hi * hi;
			hl_s1 <= hi * lo;
			ll_s1 <= lo * lo;
		end
	end

	// stage 2: hi^2 << 2lo + 2 hi lo << lo + lo^2
	always_ff @(posedge clk) begin
		if (en) begin
			sq <= (SW'(hh_s1) << (2 * LO)) + (SW'(hl_s1) << (LO + 1)) + SW'(ll_s1);
		end
	end

endmodule

### rtl/core/ppd_sqrt_cell.sv
// ppd_sqrt_cell: one restoring square root step, one root bit per cell
// uses ppd_pkg; hands radicand, remainder and partial root to the next cell

module ppd_sqrt_cell
	import ppd_pkg::*;
#(
	parameter int ROOT_WIDTH = COORD_WIDTH_DEF + 1
) (
	input  logic                    clk,
	input  logic                    en,
	input  logic [2*ROOT_WIDTH-1:0] rad_i,
	input  logic [ROOT_WIDTH+2:0]   rem_i,
	input  logic [ROOT_WIDTH-1:0]   root_i,
	output logic [2*ROOT_WIDTH-1:0] rad_o,
	output logic [ROOT_WIDTH+2:0]   rem_o,
	output logic [ROOT_WIDTH-1:0]   root_o
);

	localparam int RW = ROOT_WIDTH + 3;
	localparam int NW = 2 * ROOT_WIDTH;

	logic [RW-1:0] rem_sh;
	logic [RW-1:0] trial;
	logic [RW:0]   diff;
	logic          take;

	// remainder stays below 2^(ROOT_WIDTH+1)
	always_comb begin
		rem_sh = {rem_i[RW-3:0], rad_i[NW-1:NW-2]};
		trial  = {1'b0, root_i, 2'b01};
		diff   = {1'b0, rem_sh} - {1'b0, trial};
		take   = !diff[RW];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rad_o  <= {rad_i[NW-3:0], 2'b00};
			rem_o  <= take ? diff[RW-1:0] : rem_sh;
			root_o <= {root_i[ROOT_WIDTH-2:0], take};
		end
	end

endmodule

### rtl/core/ppd_port_checker.sv
// ppd_port_checker: port-level checks on the periodic pair distance top level
// uses ppd_pkg; bound to periodic_pair_distance_top at the end of this file

module ppd_port_checker
	import ppd_pkg::*;
#(
	parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 pair_stall,
	input logic                 dist_valid,
	input logic                 dist_stall,
	input logic [COORD_WIDTH:0] distance,
	input logic                 cfg_ready
);

	// a stalled result beat stays and holds its value
	a_dist_hold: assert property (@(posedge clk) disable iff (!arst_n)
		dist_valid && dist_stall |=> dist_valid && $stable(distance))
		else $error("stalled distance beat changed");

	// the pair side is held back only by a waiting result
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		pair_stall |-> dist_valid && dist_stall)
		else $error("pair stalled without a blocked result");

	// a pair stall means a result is still on the port next cycle
	a_stall_result: assert property (@(posedge clk) disable iff (!arst_n)
		pair_stall |=> dist_valid)
		else $error("result vanished while pair side was stalled");

	// configuration writes never wait
	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_ready)
		else $error("configuration port not ready");

endmodule

bind periodic_pair_distance_top ppd_port_checker #(.COORD_WIDTH(COORD_WIDTH)) u_ppd_port_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.pair_stall(pair_stall),
	.dist_valid(dist_valid),
	.dist_stall(dist_stall),
	.distance  (distance),
	.cfg_ready (cfg_ready)
);

### dv/ppd_pair_checker.sv
// ppd_pair_checker: watches the pair, distance and cfg channels of the pair distance block
// keeps its own register copy, predicts each distance beat and compares in order; uses ppd_pkg

module ppd_pair_checker
	import ppd_pkg::*;
#(
	parameter int CW = COORD_WIDTH_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          pair_valid,
	input  logic          pair_stall,
	input  logic [CW-1:0] point_a_x,
	input  logic [CW-1:0] point_a_y,
	input  logic [CW-1:0] point_a_z,
	input  logic [CW-1:0] point_b_x,
	input  logic [CW-1:0] point_b_y,
	input  logic [CW-1:0] point_b_z,
	input  logic          dist_valid,
	input  logic          dist_stall,
	input  logic [CW:0]   distance,
	input  logic          cfg_valid,
	input  logic          cfg_ready,
	input  cfg_reg_t      cfg_index,
	input  logic [CW-1:0] cfg_data,
	output int            mismatches,
	output int            in_flight
);

	timeunit 1ns;
	timeprecision 1ps;

	logic          wrap_on;
	logic [CW-1:0] box_len [3];
	logic [CW:0]   distance_due [$];
	int            errors = 0;

	assign mismatches = errors;

	// squared axis difference, wrapped once against the box when enabled
	function automatic longint unsigned axis_square(input logic [CW-1:0] a, input logic [CW-1:0] b,
			input logic [CW-1:0] box, input logic wrap);
		longint da, db, bl, d;
		da = a;
		db = b;
		bl = box;
		d = da - db;
		if (wrap) begin
			if (2 * d > bl)
				d = d - bl;
			else if (2 * d <= -bl)
				d = d + bl;
		end
		if (d < 0)
			d = -d;
		return d * d;
	endfunction

	// floor square root of the exact sum of squares
	function automatic logic [CW:0] pair_distance(input logic [CW-1:0] ax, input logic [CW-1:0] ay,
			input logic [CW-1:0] az, input logic [CW-1:0] bx, input logic [CW-1:0] by,
			input logic [CW-1:0] bz);
		longint unsigned sum, root, trial;
		sum = axis_square(ax, bx, box_len[0], wrap_on) + axis_square(ay, by, box_len[1], wrap_on)
			+ axis_square(az, bz, box_len[2], wrap_on);
		root = 0;
		for (int bit_pos = CW + 2; bit_pos >= 0; bit_pos--) begin
			trial = root | (64'd1 << bit_pos);
			if (trial * trial <= sum)
				root = trial;
		end
		return root[CW:0];
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		logic [CW:0] want;
		if (!arst_n) begin
			wrap_on = 1'b1;
			box_len[0] = '1;
			box_len[1] = '1;
			box_len[2] = '1;
			distance_due.delete();
			in_flight <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_PERIODIC_ENABLE: wrap_on = cfg_data[0];
					REG_BOX_SIZE_X: box_len[0] = cfg_data;
					REG_BOX_SIZE_Y: box_len[1] = cfg_data;
					REG_BOX_SIZE_Z: box_len[2] = cfg_data;
					default: ;
				endcase
			end
			if (pair_valid && !pair_stall)
				distance_due.push_back(pair_distance(point_a_x, point_a_y, point_a_z,
					point_b_x, point_b_y, point_b_z));
			if (dist_valid && !dist_stall) begin
				if (distance_due.size() == 0) begin
					$error("distance: expected none, actual %0d", distance);
					errors++;
				end else begin
					want = distance_due.pop_front();
					if (want !== distance) begin
						$error("distance: expected %0d, actual %0d", want, distance);
						errors++;
					end
				end
			end
			in_flight <= distance_due.size();
		end
	end

endmodule

### dv/periodic_pair_distance_top_tb.sv
// periodic_pair_distance_top_tb: stimulus and verdict for the periodic pair distance block
// drives pair beats, register writes and distance back-pressure; ppd_pair_checker does the checking

module periodic_pair_distance_top_tb;

	import ppd_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int CW = COORD_WIDTH_DEF;
	localparam logic [CW-1:0] COORD_MAX = '1;
	// pipeline depth of the top level
	localparam int LATENCY = 6 + CW + 1;
	localparam int ITEMS_PER_PHASE = 240;

	// register settings that the run steps through, one per phase
	typedef enum int {
		PH_RESET_DEFAULT,
		PH_PLAIN,
		PH_UNIT_BOX,
		PH_ZERO_BOX,
		PH_EVEN_BOX,
		PH_SMALL_BOX,
		PH_QUIET,
		PH_FULL_BOX
	} phase_t;

	logic          clk;
	logic          arst_n = 1'b0;
	logic          pair_valid = 1'b0;
	logic          pair_stall;
	logic [CW-1:0] point_a_x = '0;
	logic [CW-1:0] point_a_y = '0;
	logic [CW-1:0] point_a_z = '0;
	logic [CW-1:0] point_b_x = '0;
	logic [CW-1:0] point_b_y = '0;
	logic [CW-1:0] point_b_z = '0;
	logic          dist_valid;
	logic          dist_stall = 1'b0;
	logic [CW:0]   distance;
	logic          cfg_valid = 1'b0;
	logic          cfg_ready;
	cfg_reg_t      cfg_index = REG_PERIODIC_ENABLE;
	logic [CW-1:0] cfg_data = '0;

	int            mismatches;
	int            in_flight;

	// when set, neither side idles: a long stretch at full rate
	logic          calm = 1'b0;
	// box lengths currently programmed, used to aim the stimulus
	logic [CW-1:0] box_now [3];

	periodic_pair_distance_top #(
		.COORD_WIDTH(CW)
	) uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.pair_valid(pair_valid),
		.pair_stall(pair_stall),
		.point_a_x (point_a_x),
		.point_a_y (point_a_y),
		.point_a_z (point_a_z),
		.point_b_x (point_b_x),
		.point_b_y (point_b_y),
		.point_b_z (point_b_z),
		.dist_valid(dist_valid),
		.dist_stall(dist_stall),
		.distance  (distance),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	ppd_pair_checker #(
		.CW(CW)
	) u_checker (
		.clk       (clk),
		.arst_n    (arst_n),
		.pair_valid(pair_valid),
		.pair_stall(pair_stall),
		.point_a_x (point_a_x),
		.point_a_y (point_a_y),
		.point_a_z (point_a_z),
		.point_b_x (point_b_x),
		.point_b_y (point_b_y),
		.point_b_z (point_b_z),
		.dist_valid(dist_valid),
		.dist_stall(dist_stall),
		.distance  (distance),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.mismatches(mismatches),
		.in_flight (in_flight)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// watchdog: far beyond the slowest correct run
	initial begin
		#5_000_000;
		$display("RESULT: ERROR");
		$finish;
	end

	// random distance back-pressure, stall chance 28 in a hundred, unless calm
	initial begin
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			dist_stall <= calm ? 1'b0 : ($urandom_range(99) < 28);
		end
	end

	// one register write beat; the caller lowers cfg_valid after the batch
	task automatic write_reg(input cfg_reg_t idx, input logic [CW-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
	endtask

	// one pair beat, held until accepted; valid stays high for a following beat unless an idle gap follows
	task automatic send_pair(input logic [CW-1:0] ax, input logic [CW-1:0] ay,
			input logic [CW-1:0] az, input logic [CW-1:0] bx, input logic [CW-1:0] by,
			input logic [CW-1:0] bz);
		pair_valid <= 1'b1;
		point_a_x <= ax;
		point_a_y <= ay;
		point_a_z <= az;
		point_b_x <= bx;
		point_b_y <= by;
		point_b_z <= bz;
		do @(posedge clk); while (pair_stall);
		// random idle gap after the beat
		if (!calm && $urandom_range(99) < 28) begin
			pair_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < 28);
		end
	endtask

	// stop sending and wait until every predicted distance has come back
	task automatic drain;
		pair_valid <= 1'b0;
		@(posedge clk);
		while (in_flight != 0)
			@(posedge clk);
	endtask

	// program all four registers and remember the boxes for aiming
	task automatic program_regs(input logic en, input logic [CW-1:0] bx, input logic [CW-1:0] by,
			input logic [CW-1:0] bz);
		box_now[0] = bx;
		box_now[1] = by;
		box_now[2] = bz;
		write_reg(REG_PERIODIC_ENABLE, {{(CW-1){1'b0}}, en});
		write_reg(REG_BOX_SIZE_X, bx);
		write_reg(REG_BOX_SIZE_Y, by);
		write_reg(REG_BOX_SIZE_Z, bz);
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [CW-1:0] coord_in(input logic [CW-1:0] box);
		if (box == 0)
			return CW'($urandom);
		return CW'($urandom_range(box - 1, 0));
	endfunction

	function automatic logic [CW-1:0] coord_edge;
		case ($urandom_range(2))
			0: return '0;
			1: return COORD_MAX;
			default: return CW'($urandom);
		endcase
	endfunction

	// one axis of a random pair: inside the box, near the wrap point, anywhere, or extreme
	task automatic gen_axis(input logic [CW-1:0] box, output logic [CW-1:0] a,
			output logic [CW-1:0] b);
		int pick;
		longint d;
		pick = $urandom_range(99);
		if (pick < 35) begin
			a = coord_in(box);
			b = coord_in(box);
		end else if (pick < 60) begin
			d = longint'(box >> 1) + $urandom_range(4) - 2;
			if ($urandom_range(1))
				d = -d;
			if (d >= 0) begin
				b = CW'($urandom_range(longint'(COORD_MAX) - d, 0));
				a = b + CW'(d);
			end else begin
				a = CW'($urandom_range(longint'(COORD_MAX) + d, 0));
				b = a - CW'(d);
			end
		end else if (pick < 85) begin
			a = CW'($urandom);
			b = CW'($urandom);
		end else begin
			a = coord_edge();
			b = coord_edge();
		end
	endtask

	// differences straddling both wrap thresholds on every axis at once
	task automatic send_wrap_edges;
		int step [6] = '{-1, 0, 1, -1, 0, 1};
		int sgn [6] = '{1, 1, 1, -1, -1, -1};
		logic [CW-1:0] pa [3];
		logic [CW-1:0] pb [3];
		longint d;
		for (int i = 0; i < 6; i++) begin
			for (int k = 0; k < 3; k++) begin
				d = sgn[i] * (longint'(box_now[k] >> 1) + step[i]);
				if (d >= 0) begin
					pa[k] = CW'(d);
					pb[k] = '0;
				end else begin
					pa[k] = '0;
					pb[k] = CW'(-d);
				end
			end
			send_pair(pa[0], pa[1], pa[2], pb[0], pb[1], pb[2]);
		end
	endtask

	initial begin : stimulus
		phase_t ph;
		logic [CW-1:0] pa [3];
		logic [CW-1:0] pb [3];
		box_now[0] = COORD_MAX;
		box_now[1] = COORD_MAX;
		box_now[2] = COORD_MAX;
		// single reset at the start of the run
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int p = PH_RESET_DEFAULT; p <= PH_FULL_BOX; p++) begin
			ph = phase_t'(p);
			// registers only change with the pipeline empty
			drain();
			case (ph)
				PH_RESET_DEFAULT: ;
				PH_PLAIN: program_regs(1'b0, CW'($urandom_range(COORD_MAX, 1)),
					CW'($urandom_range(COORD_MAX, 1)), CW'($urandom_range(COORD_MAX, 1)));
				PH_UNIT_BOX: program_regs(1'b1, CW'(1), CW'(1), CW'(1));
				// zero box leaves every axis unwrapped
				PH_ZERO_BOX: program_regs(1'b1, '0, '0, '0);
				// even boxes make twice the difference hit the box exactly
				PH_EVEN_BOX: program_regs(1'b1, CW'($urandom_range(CW'(COORD_MAX >> 1), 1) * 2),
					CW'($urandom_range(CW'(COORD_MAX >> 1), 1) * 2),
					CW'($urandom_range(2047, 1) * 2));
				PH_SMALL_BOX: program_regs(1'b1, CW'($urandom_range(65535, 1)),
					CW'($urandom_range(65535, 1)), CW'($urandom_range(65535, 1)));
				PH_QUIET: program_regs(1'b1, CW'($urandom_range(COORD_MAX, 1)),
					CW'($urandom_range(COORD_MAX, 1)), CW'($urandom_range(65535, 1)));
				PH_FULL_BOX: program_regs(1'b1, COORD_MAX, CW'(1), COORD_MAX);
				default: ;
			endcase
			calm = (ph == PH_QUIET);

			// directed: field extremes under reset settings, wrap edges where they matter
			if (ph == PH_RESET_DEFAULT) begin
				send_pair('0, '0, '0, '0, '0, '0);
				send_pair(COORD_MAX, COORD_MAX, COORD_MAX, '0, '0, '0);
				send_pair('0, '0, '0, COORD_MAX, COORD_MAX, COORD_MAX);
				send_pair(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX);
				send_pair(COORD_MAX, '0, CW'(24'h800000), '0, COORD_MAX, CW'(24'h7FFFFF));
			end
			if (ph == PH_RESET_DEFAULT || ph == PH_ZERO_BOX || ph == PH_EVEN_BOX)
				send_wrap_edges();

			// random pairs aimed at the programmed boxes
			for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
				for (int k = 0; k < 3; k++)
					gen_axis(box_now[k], pa[k], pb[k]);
				send_pair(pa[0], pa[1], pa[2], pb[0], pb[1], pb[2]);
			end
		end

		drain();
		calm = 1'b0;
		// let any stray beat surface after the last expected one
		repeat (LATENCY + 8) @(posedge clk);
		if (mismatches == 0 && in_flight == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
